FILE: src/assert_macros.svh
// Assertion macros shared by the SHA-256 engine RTL.
// Each macro clocks on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sha256_pkg.sv
// Types, constants and bit functions of the SHA-256 engine.
// No dependencies; imported by every module of the engine.
`default_nettype none

package sha256_pkg;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LAST_RND = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd7;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic       wr_byte;
		logic       pad;
		logic       zero;
		logic       len;
		logic       shift;
		logic [5:0] pos;
		logic [7:0] data;
	} sched_ctl_t;

	typedef struct packed {
		logic init;
		logic load;
		logic step;
		logic fold;
	} rnd_ctl_t;

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage

`default_nettype wire

FILE: src/sha256_sched.sv
// Block buffer and message schedule window of the SHA-256 engine.
// Packs bytes, applies padding and length, and shifts out one schedule word per round.
// Depends on sha256_pkg.
`default_nettype none

module sha256_sched import sha256_pkg::*; (
	input  wire logic        clk,
	input  wire sched_ctl_t  ctl,
	input  wire logic [63:0] bit_len,
	output logic      [31:0] w
);

	logic [31:0] w_q [16];
	logic [31:0] w_d [16];
	logic [3:0]  idx;
	logic [4:0]  sh;
	logic [31:0] byte_w;
	logic [31:0] pad_w;
	logic [31:0] keep_m;
	logic [31:0] w_new;

	assign idx    = ctl.pos[5:2];
	assign sh     = {ctl.pos[1:0], 3'b000};
	assign byte_w = {ctl.data, 24'b0} >> sh;
	assign pad_w  = {PAD_BYTE, 24'b0} >> sh;
	assign keep_m = ~(32'hFFFF_FFFF >> sh);
	assign w_new  = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign w      = w_q[0];

	always_comb begin
		w_d = w_q;
		if (ctl.shift) begin
			for (int i = 0; i < 15; i++) begin
				w_d[i] = w_q[i + 1];
			end
			w_d[15] = w_new;
		end else begin
			if (ctl.wr_byte) begin
				if (ctl.pos[1:0] == 2'b00) begin
					w_d[idx] = byte_w;
				end else begin
					w_d[idx] = w_q[idx] | byte_w;
				end
			end
			if (ctl.pad) begin
				for (int j = 0; j < 16; j++) begin
					if (4'(j) == idx) begin
						w_d[j] = (w_q[j] & keep_m) | pad_w;
					end else if (4'(j) > idx) begin
						w_d[j] = '0;
					end
				end
			end
			if (ctl.zero) begin
				for (int j = 0; j < 16; j++) begin
					w_d[j] = '0;
				end
			end
			if (ctl.len) begin
				w_d[14] = bit_len[63:32];
				w_d[15] = bit_len[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		w_q <= w_d;
	end

endmodule

`default_nettype wire

FILE: src/sha256_round.sv
// Shared round unit and chaining hash of the SHA-256 engine.
// One compression round per step; fold adds the working words into the hash.
// Depends on sha256_pkg.
`default_nettype none

module sha256_round import sha256_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rnd_ctl_t    ctl,
	input  wire logic [5:0]  rnd,
	input  wire logic [31:0] w,
	input  wire logic [2:0]  rd_idx,
	output logic      [31:0] hash_word
);

	logic [31:0] v_q    [8];
	logic [31:0] hash_q [8];
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + bsig1(v_q[4]) + ch + ROUND_K[rnd] + w;
	assign t2  = bsig0(v_q[0]) + maj;
	assign hash_word = hash_q[rd_idx];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= hash_q;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= INIT_HASH;
		end else if (ctl.init) begin
			hash_q <= INIT_HASH;
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/sha256_hash_engine_unit.sv
// SHA-256 hash engine over a byte stream: one input byte per cycle while idle,
// one shared round unit for the 64 compression rounds. The byte that completes a 64-byte
// block starts a load, 64 rounds and a fold, during which no input is taken. Closing a
// message compresses the pad block, and a second block when the length spills into it,
// then eight digest words are offered on the output, most significant first, before
// the next input byte is taken.
// Depends on sha256_pkg, sha256_sched, sha256_round and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sha256_hash_engine_unit import sha256_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tuser,  // byte_present
	input  wire logic        s_axis_tlast,  // end_of_message
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // digest_word
	output logic      [2:0]  m_axis_tuser,  // word_index
	output logic             m_axis_tlast   // last_word
);

	st_t         state_q, state_d;
	st_t         after_q, after_d;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic [60:0] count_q;
	logic        count_inc;
	logic        count_clr;
	logic        rnd_inc;
	logic        oidx_inc;
	sched_ctl_t  sctl;
	rnd_ctl_t    rctl;
	logic [31:0] w;
	logic [31:0] hash_word;

	sha256_sched u_sched (
		.clk     (clk),
		.ctl     (sctl),
		.bit_len ({count_q, 3'b000}),
		.w       (w)
	);

	sha256_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rctl),
		.rnd       (rnd_q),
		.w         (w),
		.rd_idx    (oidx_q),
		.hash_word (hash_word)
	);

	assign m_axis_tdata = hash_word;
	assign m_axis_tuser = oidx_q;
	assign m_axis_tlast = (oidx_q == LAST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= ST_IDLE;
			rnd_q   <= '0;
			oidx_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
			if (rnd_inc) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (oidx_inc) begin
				oidx_q <= oidx_q + 3'd1;
			end
			if (count_clr) begin
				count_q <= '0;
			end else if (count_inc) begin
				count_q <= count_q + 61'd1;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		after_d       = after_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		count_inc     = 1'b0;
		count_clr     = 1'b0;
		rnd_inc       = 1'b0;
		oidx_inc      = 1'b0;
		sctl          = '0;
		sctl.pos      = count_q[5:0];
		sctl.data     = s_axis_tdata;
		rctl          = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser) begin
						sctl.wr_byte = 1'b1;
						count_inc    = 1'b1;
						if (count_q[5:0] == 6'h3F) begin
							state_d = ST_LOAD;
							after_d = s_axis_tlast ? ST_PAD : ST_IDLE;
						end else if (s_axis_tlast) begin
							state_d = ST_PAD;
						end
					end else if (s_axis_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_LOAD: begin
				rctl.load = 1'b1;
				state_d   = ST_ROUND;
			end
			ST_ROUND: begin
				rctl.step  = 1'b1;
				sctl.shift = 1'b1;
				rnd_inc    = 1'b1;
				if (rnd_q == LAST_RND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				rctl.fold = 1'b1;
				state_d   = after_q;
			end
			ST_PAD: begin
				sctl.pad = 1'b1;
				state_d  = ST_LOAD;
				if (count_q[5:3] == 3'b111) begin
					after_d = ST_LEN;
				end else begin
					sctl.len = 1'b1;
					after_d  = ST_OUT;
				end
			end
			ST_LEN: begin
				sctl.zero = 1'b1;
				sctl.len  = 1'b1;
				after_d   = ST_OUT;
				state_d   = ST_LOAD;
			end
			ST_OUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					oidx_inc = 1'b1;
					if (oidx_q == LAST_WORD) begin
						rctl.init = 1'b1;
						count_clr = 1'b1;
						after_d   = ST_IDLE;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_IMP(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input taken during digest output")
	`ASSERT_NXT(a_round_end, (state_q == ST_ROUND) && (rnd_q == LAST_RND), state_q == ST_FOLD, "round count did not end in fold")
	`ASSERT_NXT(a_back_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && (count_q == 61'd0), "engine not idle after last digest word")
	`ASSERT_IMP(a_out_from_start, $rose(m_axis_tvalid), oidx_q == 3'd0, "digest output did not start at word zero")

endmodule

`default_nettype wire
